[rtl/core/ita_pkg.sv]
`default_nettype none
package ita_pkg;

	localparam int unsigned VALUE_W    = 64;
	localparam int unsigned DIGIT_W    = 4;
	localparam int unsigned NUM_DIGITS = 22;
	localparam int unsigned DEC_DIGITS = 20;
	localparam int unsigned HEX_DIGITS = 16;
	localparam int unsigned OCT_DIGITS = 22;
	localparam int unsigned DIG_REG_W  = NUM_DIGITS * DIGIT_W;
	localparam int unsigned BCD_W      = DEC_DIGITS * DIGIT_W;
	localparam int unsigned CNT_W      = $clog2(NUM_DIGITS + 1);
	localparam int unsigned ITER_W     = $clog2(VALUE_W + 1);

	localparam logic [1:0] MODE_DEC  = 2'd0;
	localparam logic [1:0] MODE_HEXL = 2'd1;
	localparam logic [1:0] MODE_HEXU = 2'd2;
	localparam logic [1:0] MODE_OCT  = 2'd3;

	localparam logic [7:0] CHAR_MINUS   = 8'h2d;
	localparam logic [7:0] CHAR_ZERO    = 8'h30;
	localparam logic [7:0] CHAR_LOWER_A = 8'h61;
	localparam logic [7:0] CHAR_UPPER_A = 8'h41;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic [1:0]         mode;
	} src_t;

	typedef struct packed {
		logic [7:0] char_code;
		logic       last;
	} res_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_SKIP,
		ST_EMIT
	} state_t;

	function automatic logic [7:0] digit_char(input logic [DIGIT_W-1:0] d, input logic upper);
		logic [7:0] base;
		begin
			base = upper ? CHAR_UPPER_A : CHAR_LOWER_A;
			if (d < 4'd10) begin
				digit_char = CHAR_ZERO + {4'd0, d};
			end else begin
				digit_char = base + {4'd0, d} - 8'd10;
			end
		end
	endfunction

endpackage
`default_nettype wire

[rtl/core/ita_bcd_unit.sv]
`default_nettype none
module ita_bcd_unit (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [ita_pkg::VALUE_W-1:0] mag,
	output logic                            done,
	output logic [ita_pkg::BCD_W-1:0]       bcd
);
	import ita_pkg::*;

	logic [VALUE_W-1:0] bin_q;
	logic [BCD_W-1:0]   bcd_q;
	logic [BCD_W-1:0]   adj;
	logic [ITER_W-1:0]  iter_q;
	logic               busy_q;
	logic               done_q;

	// Shift-and-add-3: every BCD digit of five or more is corrected before the shift.
	always_comb begin
		logic [DIGIT_W-1:0] dg;
		dg  = '0;
		adj = '0;
		for (int i = 0; i < DEC_DIGITS; i++) begin
			dg = bcd_q[i*DIGIT_W +: DIGIT_W];
			adj[i*DIGIT_W +: DIGIT_W] = (dg >= 4'd5) ? dg + 4'd3 : dg;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			iter_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				iter_q <= ITER_W'(VALUE_W);
			end else if (busy_q) begin
				iter_q <= iter_q - ITER_W'(1);
				if (iter_q == ITER_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			bin_q <= mag;
			bcd_q <= '0;
		end else if (busy_q) begin
			bcd_q <= {adj[BCD_W-2:0], bin_q[VALUE_W-1]};
			bin_q <= {bin_q[VALUE_W-2:0], 1'b0};
		end
	end

	assign done = done_q;
	assign bcd  = bcd_q;

endmodule
`default_nettype wire

[rtl/core/integer_to_ascii_converter.sv]
// Channel  Direction  Payload           Handshake
// src      in         value, mode       src_valid / src_ready
// res      out        char_code, last   res_valid / res_ready
//
// Decimal: the accept, the conversion in the shift-and-add-3 unit, the skip of leading zeros,
// then one character per send, with a minus sign first for a negative value.
// Hex and octal skip the conversion and go from the accept straight to the leading-zero skip.
// src_ready is high only while idle; the last character may still wait in the output
// register when the next transaction is taken, and a stalled res channel holds the send state.
// Reset clears the sequencer, the conversion unit and the output valid flag.
`default_nettype none
module integer_to_ascii_converter (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          src_valid,
	output logic               src_ready,
	input  wire ita_pkg::src_t src_data,
	output logic               res_valid,
	input  wire logic          res_ready,
	output ita_pkg::res_t      res_data
);
	import ita_pkg::*;

	state_t               state_q, state_d;
	logic [DIG_REG_W-1:0] dig_q, dig_d;
	logic [CNT_W-1:0]     cnt_q, cnt_d;
	logic                 neg_q, neg_d;
	logic                 upper_q, upper_d;
	logic                 ov_q, ov_d;
	res_t                 od_q, od_d;
	logic                 is_neg;
	logic [VALUE_W-1:0]   mag;
	logic [DIG_REG_W-1:0] oct_dig;
	logic                 bcd_start;
	logic                 bcd_done;
	logic [BCD_W-1:0]     bcd;
	logic [DIGIT_W-1:0]   top_dig;

	assign is_neg  = (src_data.mode == MODE_DEC) && src_data.value[VALUE_W-1];
	assign mag     = is_neg ? VALUE_W'(0) - src_data.value : src_data.value;
	assign top_dig = dig_q[DIG_REG_W-1 -: DIGIT_W];

	always_comb begin
		oct_dig = '0;
		for (int i = 0; i < OCT_DIGITS - 1; i++) begin
			oct_dig[i*DIGIT_W +: DIGIT_W] = {1'b0, src_data.value[i*3 +: 3]};
		end
		oct_dig[DIG_REG_W-1 -: DIGIT_W] = {3'b000, src_data.value[VALUE_W-1]};
	end

	ita_bcd_unit u_bcd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (bcd_start),
		.mag    (mag),
		.done   (bcd_done),
		.bcd    (bcd)
	);

	always_comb begin
		state_d   = state_q;
		dig_d     = dig_q;
		cnt_d     = cnt_q;
		neg_d     = neg_q;
		upper_d   = upper_q;
		ov_d      = ov_q;
		od_d      = od_q;
		bcd_start = 1'b0;
		src_ready = 1'b0;
		if (ov_q && res_ready) begin
			ov_d = 1'b0;
		end
		unique case (state_q)
			ST_IDLE: begin
				src_ready = 1'b1;
				if (src_valid) begin
					neg_d   = is_neg;
					upper_d = (src_data.mode == MODE_HEXU);
					unique case (src_data.mode)
						MODE_DEC: begin
							bcd_start = 1'b1;
							state_d   = ST_CONV;
						end
						MODE_HEXL, MODE_HEXU: begin
							dig_d   = {src_data.value, (DIG_REG_W - VALUE_W)'(0)};
							cnt_d   = CNT_W'(HEX_DIGITS);
							state_d = ST_SKIP;
						end
						MODE_OCT: begin
							dig_d   = oct_dig;
							cnt_d   = CNT_W'(OCT_DIGITS);
							state_d = ST_SKIP;
						end
						default: begin
							state_d = ST_IDLE;
						end
					endcase
				end
			end
			ST_CONV: begin
				if (bcd_done) begin
					dig_d   = {bcd, (DIG_REG_W - BCD_W)'(0)};
					cnt_d   = CNT_W'(DEC_DIGITS);
					state_d = ST_SKIP;
				end
			end
			ST_SKIP: begin
				if (top_dig == '0 && cnt_q > CNT_W'(1)) begin
					dig_d = {dig_q[DIG_REG_W-DIGIT_W-1:0], DIGIT_W'(0)};
					cnt_d = cnt_q - CNT_W'(1);
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (!ov_q || res_ready) begin
					ov_d = 1'b1;
					if (neg_q) begin
						od_d.char_code = CHAR_MINUS;
						od_d.last      = 1'b0;
						neg_d          = 1'b0;
					end else begin
						od_d.char_code = digit_char(top_dig, upper_q);
						od_d.last      = (cnt_q == CNT_W'(1));
						dig_d          = {dig_q[DIG_REG_W-DIGIT_W-1:0], DIGIT_W'(0)};
						cnt_d          = cnt_q - CNT_W'(1);
						if (cnt_q == CNT_W'(1)) begin
							state_d = ST_IDLE;
						end
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ov_q    <= 1'b0;
			cnt_q   <= '0;
			neg_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			ov_q    <= ov_d;
			cnt_q   <= cnt_d;
			neg_q   <= neg_d;
		end
	end

	always_ff @(posedge clk) begin
		dig_q   <= dig_d;
		upper_q <= upper_d;
		od_q    <= od_d;
	end

	assign res_valid = ov_q;
	assign res_data  = od_q;

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		src_valid && src_ready |=> state_q != ST_IDLE)
		else $error("accepted transaction did not start the sequencer");

	a_done_in_conv: assert property (@(posedge clk) disable iff (!arst_n)
		bcd_done |-> state_q == ST_CONV)
		else $error("conversion finished outside the conversion state");

	a_emit_has_digits: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> cnt_q != '0)
		else $error("send state entered with no digits left");

endmodule
`default_nettype wire

[verif/tb_integer_to_ascii_converter.sv]
`timescale 1ns / 100ps
module tb_integer_to_ascii_converter;
	import ita_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic src_valid = 1'b0;
	logic src_ready;
	src_t src_data = '0;
	logic res_valid;
	logic res_ready = 1'b0;
	res_t res_data;

	src_t pending_numbers[$];
	res_t expected_chars[$];
	logic src_taken = 1'b0;
	logic calm = 1'b0;
	logic hold_request = 1'b0;
	int unsigned src_gap = 0;
	int unsigned res_stall = 0;
	int unsigned failures = 0;

	integer_to_ascii_converter dut (
		.clk(clk),
		.arst_n(arst_n),
		.src_valid(src_valid),
		.src_ready(src_ready),
		.src_data(src_data),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res_data(res_data)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (calm || roll < 60) begin
			return 0;
		end else if (roll < 90) begin
			return $urandom_range(1, 3);
		end else if (roll < 98) begin
			return $urandom_range(4, 10);
		end
		return $urandom_range(20, 60);
	endfunction

	function automatic void predict_text(input src_t item);
		logic [63:0] mag;
		logic [63:0] radix;
		logic [3:0] digit;
		logic [7:0] letter_a;
		logic [7:0] text[$];
		logic neg;
		res_t one;
		neg = 1'b0;
		mag = item.value;
		letter_a = (item.mode == MODE_HEXU) ? CHAR_UPPER_A : CHAR_LOWER_A;
		case (item.mode)
			MODE_DEC: begin
				radix = 64'd10;
				if (item.value[63]) begin
					neg = 1'b1;
					mag = 64'd0 - item.value;
				end
			end
			MODE_OCT: begin
				radix = 64'd8;
			end
			default: begin
				radix = 64'd16;
			end
		endcase
		do begin
			digit = 4'(mag % radix);
			text.push_front((digit < 4'd10) ? CHAR_ZERO + 8'(digit) : letter_a + 8'(digit) - 8'd10);
			mag = mag / radix;
		end while (mag != 64'd0);
		if (neg) begin
			one.char_code = CHAR_MINUS;
			one.last = 1'b0;
			expected_chars.push_back(one);
		end
		foreach (text[i]) begin
			one.char_code = text[i];
			one.last = (i == text.size() - 1);
			expected_chars.push_back(one);
		end
	endfunction

	function automatic src_t random_number();
		src_t item;
		logic [63:0] v;
		int unsigned kind;
		int unsigned len;
		v = {$urandom, $urandom};
		kind = $urandom_range(0, 9);
		if (kind < 4) begin
			len = $urandom_range(0, 64);
			v = v & ((64'd1 << len) - 64'd1);
		end else if (kind < 6) begin
			v = 64'd0 - (v >> $urandom_range(1, 63));
		end else if (kind == 6) begin
			case ($urandom_range(0, 3))
				0: v = 64'd0;
				1: v = '1;
				2: v = 64'h8000_0000_0000_0000;
				default: v = 64'h7fff_ffff_ffff_ffff;
			endcase
		end
		item.value = v;
		item.mode = 2'($urandom_range(0, 3));
		return item;
	endfunction

	task automatic queue_number(input logic [63:0] v, input logic [1:0] m);
		src_t item;
		item.value = v;
		item.mode = m;
		pending_numbers.push_back(item);
	endtask

	always @(negedge clk) begin
		if (!arst_n) begin
			src_valid <= 1'b0;
		end else if (!src_valid || src_taken) begin
			if (src_gap > 0) begin
				src_gap = src_gap - 1;
				src_valid <= 1'b0;
			end else if (pending_numbers.size() > 0) begin
				src_valid <= 1'b1;
				src_data <= pending_numbers.pop_front();
				src_gap = pick_gap();
			end else begin
				src_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			res_ready <= 1'b0;
		end else if (hold_request) begin
			hold_request = 1'b0;
			res_stall = 400;
			res_ready <= 1'b0;
		end else if (res_stall > 0) begin
			res_stall = res_stall - 1;
			res_ready <= 1'b0;
		end else begin
			res_stall = pick_gap();
			res_ready <= (res_stall == 0);
		end
	end

	always @(posedge clk) begin
		res_t want;
		src_taken = src_valid && src_ready;
		if (src_taken) begin
			predict_text(src_data);
		end
		if (res_valid && res_ready) begin
			if (expected_chars.size() == 0) begin
				$error("unexpected character %h with last %b", res_data.char_code, res_data.last);
				failures++;
			end else begin
				want = expected_chars.pop_front();
				if (res_data.char_code !== want.char_code) begin
					$error("char_code mismatch: expected %h, got %h", want.char_code,
						res_data.char_code);
					failures++;
				end
				if (res_data.last !== want.last) begin
					$error("last mismatch: expected %b, got %b", want.last, res_data.last);
					failures++;
				end
			end
		end
	end

	initial begin
		#40_000_000;
		$display("tb: failure");
		$finish;
	end

	initial begin
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		queue_number(64'd0, MODE_DEC);
		queue_number(64'd0, MODE_HEXL);
		queue_number(64'd0, MODE_HEXU);
		queue_number(64'd0, MODE_OCT);
		queue_number('1, MODE_DEC);
		queue_number('1, MODE_HEXL);
		queue_number('1, MODE_HEXU);
		queue_number('1, MODE_OCT);
		queue_number(64'h8000_0000_0000_0000, MODE_DEC);
		queue_number(64'h7fff_ffff_ffff_ffff, MODE_DEC);
		queue_number(64'h8000_0000_0000_0001, MODE_DEC);
		queue_number(64'd1, MODE_DEC);
		queue_number(64'd9, MODE_DEC);
		queue_number(64'd10, MODE_DEC);
		queue_number(64'd15, MODE_HEXL);
		queue_number(64'd16, MODE_HEXU);
		queue_number(64'd7, MODE_OCT);
		queue_number(64'd8, MODE_OCT);
		queue_number(64'h0123_4567_89ab_cdef, MODE_HEXL);
		queue_number(64'hfedc_ba98_7654_3210, MODE_HEXU);
		queue_number(64'h8000_0000_0000_0000, MODE_OCT);
		queue_number(64'd10_000_000_000_000_000_000, MODE_DEC);
		wait (pending_numbers.size() == 0 && !src_valid && expected_chars.size() == 0);

		for (int batch = 0; batch < 5; batch++) begin
			calm = (batch == 2);
			for (int n = 0; n < 92; n++) begin
				pending_numbers.push_back(random_number());
			end
			if (batch == 1) begin
				hold_request = 1'b1;
			end
			wait (pending_numbers.size() == 0 && !src_valid && expected_chars.size() == 0);
		end

		repeat (100) @(posedge clk);
		if (failures == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end
endmodule
